// ===== rtl/core/stack_with_min_max_mean_unit_defines.svh =====
// Assertion macros for the stack unit
`ifndef STACK_WITH_MIN_MAX_MEAN_UNIT_DEFINES_SVH
`define STACK_WITH_MIN_MAX_MEAN_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define STK_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define STK_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m failed");
`define STK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m failed");
`else
`define STK_ASSERT(lbl, clk, rst, prop)
`define STK_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define STK_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/stk_pkg.sv =====
`default_nettype none
package stk_pkg;
   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = 32 + CNT_W;
   localparam int STEP_W = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {
      REQ_PUSH  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_code_type;

   typedef enum logic [1:0] {
      SH_HOLD,
      SH_DOWN,
      SH_UP
   } shift_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] dividend;
      logic [CNT_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// ===== rtl/core/stk_cell.sv =====
`default_nettype none
module stk_cell
   import stk_pkg::*;
(
   input  wire logic        clock,
   input  wire shift_type   shift,
   input  wire logic [31:0] from_prev,
   input  wire logic [31:0] from_next,
   output logic      [31:0] word
);
   logic [31:0] word_ff;
   logic [31:0] word_in;

   always_comb begin
      case (shift)
         SH_DOWN: word_in = from_prev;
         SH_UP:   word_in = from_next;
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
endmodule
`default_nettype wire

// ===== rtl/core/stk_div.sv =====
`default_nettype none
module stk_div
   import stk_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic               running_ff, running_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W:0]     rem_shift;
   logic [CNT_W:0]     rem_diff;
   logic [SUM_W-1:0]   mag;
   logic [SUM_W-1:0]   signed_quo;

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      neg_in     = neg_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dvs_in     = dvs_ff;
      mag        = div_req.dividend[SUM_W-1] ? SUM_W'(-div_req.dividend)
                                             : SUM_W'(div_req.dividend);
      rem_shift  = {rem_ff, quo_ff[SUM_W-1]};
      rem_diff   = rem_shift - {1'b0, dvs_ff};
      if (div_req.start) begin
         running_in = 1'b1;
         step_in    = STEP_W'(SUM_W);
         neg_in     = div_req.dividend[SUM_W-1];
         rem_in     = '0;
         quo_in     = mag;
         dvs_in     = div_req.divisor;
      end else if (running_ff) begin
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = rem_diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         step_ff    <= step_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign signed_quo       = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = signed_quo[31:0];
endmodule
`default_nettype wire

// ===== rtl/core/stack_with_min_max_mean_unit.sv =====
`default_nettype none
// Bounded LIFO stack of signed Q16.16 words with a max/min/mean query.
// Request: start with req_type and req_value; a transfer happens at a rising
// edge with start high and busy low. req_type: push, pop, query (code 3 is
// a no-op reporting ok).
// Response: rsp_valid is high for exactly one cycle with rsp_status,
// rsp_largest, rsp_smallest, rsp_average and rsp_entry_count. The receiver
// has no backpressure; every response is taken in the cycle it is shown.
// Push, pop, no-op and empty query respond in the cycle after the
// transfer and busy never rises, so one request per cycle is accepted.
// A non-empty query is answered after a walk and a division, and no new
// request is taken meanwhile: the storage cells rotate once around the
// ring, one entry per cycle past the accumulator, then a one-bit-per-cycle
// restoring divider forms the mean.
// busy stays high until the response is shown.
// Reset clears the fill level and all control state; the stack is empty.
// Storage words are not cleared and only written entries are ever read.
module stack_with_min_max_mean_unit
   import stk_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_type,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_largest,
   output logic signed [31:0]      rsp_smallest,
   output logic signed [31:0]      rsp_average,
   output logic [4:0]              rsp_entry_count
);
`include "stack_with_min_max_mean_unit_defines.svh"

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [IDX_W-1:0]        walk_ff, walk_in;
   logic signed [31:0]      hi_ff, hi_in;
   logic signed [31:0]      lo_ff, lo_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic signed [31:0]      rsp_largest_ff, rsp_largest_in;
   logic signed [31:0]      rsp_smallest_ff, rsp_smallest_in;
   logic signed [31:0]      rsp_average_ff, rsp_average_in;
   logic [4:0]              rsp_count_ff, rsp_count_in;
   shift_type               shift;
   logic [31:0]             cell_word [DEPTH];
   logic signed [31:0]      top_word;
   logic                    walk_hit;
   logic [31:0]             fill_wide;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      stk_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .from_prev ((i == 0) ? req_value : cell_word[(i == 0) ? 0 : i - 1]),
         .from_next (cell_word[(i + 1) % DEPTH]),
         .word      (cell_word[i])
      );
   end

   stk_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign top_word  = cell_word[0];
   assign walk_hit  = CNT_W'(walk_ff) < fill_ff;
   assign fill_wide = 32'(fill_in);

   always_comb begin
      state_in         = state_ff;
      fill_in          = fill_ff;
      walk_in          = walk_ff;
      hi_in            = hi_ff;
      lo_in            = lo_ff;
      sum_in           = sum_ff;
      shift            = SH_HOLD;
      rsp_valid_in     = 1'b0;
      rsp_status_in    = STS_OK;
      rsp_largest_in   = '0;
      rsp_smallest_in  = '0;
      rsp_average_in   = '0;
      div_req.start    = 1'b0;
      div_req.dividend = sum_ff;
      div_req.divisor  = fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               case (req_code_type'(req_type))
                  REQ_PUSH: begin
                     if (fill_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        shift   = SH_DOWN;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  REQ_POP: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        shift   = SH_UP;
                        fill_in = fill_ff - 1'b1;
                     end
                  end
                  REQ_QUERY: begin
                     if (fill_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        walk_in      = '0;
                        state_in     = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            shift   = SH_UP;
            walk_in = walk_ff + 1'b1;
            if (walk_ff == '0) begin
               hi_in  = top_word;
               lo_in  = top_word;
               sum_in = SUM_W'(top_word);
            end else if (walk_hit) begin
               if (top_word > hi_ff) hi_in = top_word;
               if (top_word < lo_ff) lo_in = top_word;
               sum_in = sum_ff + SUM_W'(top_word);
            end
            if (walk_ff == IDX_W'(DEPTH - 1)) begin
               div_req.start    = 1'b1;
               div_req.dividend = sum_in;
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               rsp_valid_in    = 1'b1;
               rsp_largest_in  = hi_ff;
               rsp_smallest_in = lo_ff;
               rsp_average_in  = div_rsp.quotient;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_count_in = fill_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hi_ff           <= hi_in;
      lo_ff           <= lo_in;
      sum_ff          <= sum_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_largest_ff  <= rsp_largest_in;
      rsp_smallest_ff <= rsp_smallest_in;
      rsp_average_ff  <= rsp_average_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_largest     = rsp_largest_ff;
   assign rsp_smallest    = rsp_smallest_ff;
   assign rsp_average     = rsp_average_ff;
   assign rsp_entry_count = rsp_count_ff;

   `STK_ASSERT(a_fill_bound, clock, reset, fill_ff <= CNT_W'(DEPTH))
   `STK_ASSERT_NEXT(a_xfer_answered, clock, reset, start && !busy, rsp_valid || busy)
   `STK_ASSERT_IMPL(a_walk_quiet, clock, reset, state_ff == ST_WALK, !rsp_valid_ff)
   `STK_ASSERT_IMPL(a_div_done_state, clock, reset, div_rsp.done, state_ff == ST_DIV)
   `STK_ASSERT_NEXT(a_query_fill_kept, clock, reset, state_ff != ST_IDLE, $stable(fill_ff))
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
   import stk_pkg::*;

   localparam int LIMIT  = 600000;
   localparam int SETTLE = DEPTH + SUM_W + 8;

   typedef struct {
      status_code_type    status;
      logic signed [31:0] largest;
      logic signed [31:0] smallest;
      logic signed [31:0] average;
      logic [4:0]         entry_count;
   } stack_result_type;

   class stack_scoreboard;
      logic signed [31:0] words [DEPTH];
      int                 level;
      stack_result_type   awaited_results [$];
      int                 fails;

      function new();
         level = 0;
         fails = 0;
      endfunction

      task report(string msg);
         if (fails < 40) $display("mismatch at %0t: %s", $time, msg);
         fails++;
      endtask

      // apply one accepted request to the shadow stack and queue its result
      function void note_request(logic [1:0] code, logic signed [31:0] word);
         stack_result_type r;
         longint           total;
         r.status = STS_OK;
         r.largest = '0;
         r.smallest = '0;
         r.average = '0;
         case (req_code_type'(code))
            REQ_PUSH: begin
               if (level >= DEPTH) r.status = STS_FULL;
               else begin
                  words[level] = word;
                  level++;
               end
            end
            REQ_POP: begin
               if (level == 0) r.status = STS_EMPTY;
               else level--;
            end
            REQ_QUERY: begin
               if (level == 0) r.status = STS_EMPTY;
               else begin
                  total = 0;
                  r.largest = words[level-1];
                  r.smallest = words[level-1];
                  for (int i = 0; i < level; i++) begin
                     total += words[i];
                     if (words[i] > r.largest) r.largest = words[i];
                     if (words[i] < r.smallest) r.smallest = words[i];
                  end
                  r.average = 32'(total / level);
               end
            end
            default: ;
         endcase
         r.entry_count = level[4:0];
         awaited_results.push_back(r);
      endfunction

      task check_response(logic [1:0] st, logic signed [31:0] hi,
                          logic signed [31:0] lo, logic signed [31:0] avg,
                          logic [4:0] cnt);
         stack_result_type e;
         if (awaited_results.size() == 0) begin
            report("response with no transfer pending");
            return;
         end
         e = awaited_results.pop_front();
         if (st !== e.status)
            report($sformatf("status got %0d exp %0d", st, e.status));
         if (hi !== e.largest)
            report($sformatf("largest got %h exp %h", hi, e.largest));
         if (lo !== e.smallest)
            report($sformatf("smallest got %h exp %h", lo, e.smallest));
         if (avg !== e.average)
            report($sformatf("average got %h exp %h", avg, e.average));
         if (cnt !== e.entry_count)
            report($sformatf("entry_count got %0d exp %0d", cnt, e.entry_count));
      endtask

      task close_out();
         if (awaited_results.size() != 0)
            report($sformatf("%0d responses never arrived", awaited_results.size()));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_type = REQ_NONE;
   logic signed [31:0] req_value = '0;
   logic               busy;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_largest;
   logic signed [31:0] rsp_smallest;
   logic signed [31:0] rsp_average;
   logic [4:0]         rsp_entry_count;

   stack_scoreboard sb;
   int              cycle_count = 0;
   bit              quiet = 1'b0;

   stack_with_min_max_mean_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_largest     (rsp_largest),
      .rsp_smallest    (rsp_smallest),
      .rsp_average     (rsp_average),
      .rsp_entry_count (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_request(req_type, req_value);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_status, rsp_largest, rsp_smallest, rsp_average,
                           rsp_entry_count);
   end

   // returns at the edge where the transfer happens; start stays high
   task automatic send_req(input req_code_type code, input logic [31:0] word);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 12) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_type <= code;
      req_value <= word;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'(int'($urandom_range(0, 16)) - 8);
         3: return {16'($urandom_range(0, 65535)), 16'h0000};
         default: return $urandom;
      endcase
   endfunction

   task automatic run_directed();
      logic [31:0] fill_words [14];
      fill_words = '{32'h0, 32'hffffffff, 32'h1, 32'h00010000, 32'hffff0000,
                     32'h7fffffff, 32'h80000000, 32'h0000ffff, 32'hffff8000,
                     32'h55555555, 32'haaaaaaaa, 32'h3, 32'hfffffffd, 32'h12345678};
      send_req(REQ_QUERY, 32'hffffffff);
      send_req(REQ_POP, 32'h0);
      send_req(REQ_NONE, 32'hdeadbeef);
      send_req(REQ_PUSH, 32'h7fffffff);
      send_req(REQ_PUSH, 32'h80000000);
      // mean of -1/2 truncates to zero
      send_req(REQ_QUERY, 32'h0);
      foreach (fill_words[i]) send_req(REQ_PUSH, fill_words[i]);
      send_req(REQ_PUSH, 32'h00000042);
      send_req(REQ_QUERY, 32'h0);
      send_req(REQ_NONE, 32'h0);
      send_req(REQ_POP, 32'hffffffff);
   endtask

   task automatic run_random(input int n);
      int           sent;
      int           phase_left;
      bit           filling;
      int           r;
      req_code_type code;
      sent = 0;
      phase_left = 0;
      filling = 1'b1;
      while (sent < n) begin
         if (phase_left == 0) begin
            filling = $urandom_range(0, 1);
            phase_left = $urandom_range(10, 50);
         end
         phase_left--;
         quiet = (sent >= 700 && sent < 1100);
         r = $urandom_range(0, 99);
         if (filling)
            code = (r < 50) ? REQ_PUSH : (r < 70) ? REQ_POP :
                   (r < 96) ? REQ_QUERY : REQ_NONE;
         else
            code = (r < 20) ? REQ_PUSH : (r < 65) ? REQ_POP :
                   (r < 96) ? REQ_QUERY : REQ_NONE;
         send_req(code, pick_word());
         if (code != REQ_NONE) sent++;
      end
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(1950);
      start <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      sb.close_out();
      if (sb.fails == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
